/* src/clpm_pkg.sv */
// Shared types and constants for the cell limit persistence monitor.
package clpm_pkg;

    localparam int DEF_MODULES = 8;
    localparam int DEF_CELLS   = 6;
    localparam int DEF_SENSORS = 4;

    localparam int CNT_W   = 10;
    localparam int VSUM_W  = 20;
    localparam int TSUM_W  = 32;
    localparam int SMP_W   = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = 10'd1023;
    localparam logic [3:0]       ROUND_LAST_IDX = 4'd9;

    localparam logic [15:0]      VOLT_UNDER_RST = 16'd31000;
    localparam logic [15:0]      VOLT_OVER_RST  = 16'd41000;
    localparam logic signed [7:0] TEMP_UNDER_RST = 8'sd10;
    localparam logic signed [7:0] TEMP_OVER_RST  = 8'sd55;
    localparam logic [CNT_W-1:0] PERSIST_RST    = 10'd10;

    // Reciprocal of ten, exact for any dividend below 2**34.
    localparam logic [TSUM_W-1:0] DIV_MUL   = 32'd3435973837;
    localparam int                DIV_SHIFT = 35;

    localparam int FIFO_DEPTH = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLT_UNDER = 3'd0,
        CFG_VOLT_OVER  = 3'd1,
        CFG_TEMP_UNDER = 3'd2,
        CFG_TEMP_OVER  = 3'd3,
        CFG_PERSIST    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic             fault;
        logic             avalid;
        logic [SMP_W-1:0] value;
    } t_result;

endpackage

/* src/clpm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module clpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/cell_limit_persistence_monitor.sv */
// Top level of the cell limit persistence monitor.
// Accepted transactions pass stages 1 to 4 into an eight-entry result queue.
// Throughput: one transaction per cycle while credit for a queue entry remains.
// Channel state is read, updated and written back through two RAMs with registered reads.
// Reset clears the state through per-entry valid flops, so no clearing pass runs.
// Reset also returns the limits and persistence count to their default values.
module cell_limit_persistence_monitor
    import clpm_pkg::*;
#(
    parameter int MODULES            = DEF_MODULES,
    parameter int CELLS_PER_MODULE   = DEF_CELLS,
    parameter int SENSORS_PER_MODULE = DEF_SENSORS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_module_req,
    input  logic [2:0]            i_position,
    input  logic                  i_is_temperature,
    input  logic signed [SMP_W-1:0] i_sample_value,
    input  logic                  i_round_last,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_fault,
    output logic                  o_average_valid,
    output logic signed [SMP_W-1:0] o_average_value,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int V_CH = MODULES * CELLS_PER_MODULE;
    localparam int T_CH = MODULES * SENSORS_PER_MODULE;
    localparam int VAW  = (V_CH > 1) ? $clog2(V_CH) : 1;
    localparam int TAW  = (T_CH > 1) ? $clog2(T_CH) : 1;
    localparam int CAW  = (VAW > TAW) ? VAW : TAW;
    localparam int VW   = CNT_W + VSUM_W;
    localparam int TW   = CNT_W + TSUM_W;
    localparam int FPW  = $clog2(FIFO_DEPTH);
    localparam int FCW  = $clog2(FIFO_DEPTH + 1);

    // Configuration registers.
    logic [15:0]        r_volt_under;
    logic [15:0]        r_volt_over;
    logic signed [7:0]  r_temp_under;
    logic signed [7:0]  r_temp_over;
    logic [CNT_W-1:0]   r_persist;

    logic               in_accept;
    logic               out_pop;
    logic [3:0]         r_round;
    logic               tenth;

    // Stage 0 address generation.
    logic               mod_ok;
    logic               in_range;
    logic [VAW-1:0]     volt_addr;
    logic [TAW-1:0]     temp_addr;

    // Stage 1 registers and read-modify-write logic.
    logic                 r_s1_valid;
    logic                 r_s1_temp;
    logic                 r_s1_in_range;
    logic                 r_s1_tenth;
    logic [CAW-1:0]       r_s1_addr;
    logic signed [SMP_W-1:0] r_s1_sample;

    logic [V_CH-1:0]      r_vvld;
    logic [T_CH-1:0]      r_tvld;
    logic [VW-1:0]        volt_rdata;
    logic [TW-1:0]        temp_rdata;
    logic [VW-1:0]        volt_wdata;
    logic [TW-1:0]        temp_wdata;
    logic                 volt_we;
    logic                 temp_we;

    logic                 r_fwd_valid;
    logic                 r_fwd_temp;
    logic [CAW-1:0]       r_fwd_addr;
    logic [CNT_W-1:0]     r_fwd_cnt;
    logic [TSUM_W-1:0]    r_fwd_sum;

    logic                 fwd_hit;
    logic                 entry_vld;
    logic [CNT_W-1:0]     old_cnt;
    logic [TSUM_W-1:0]    old_sum;
    logic [TSUM_W-1:0]    add_val;
    logic [TSUM_W-1:0]    sum_full;
    logic [TSUM_W-1:0]    new_sum;
    logic [TSUM_W-1:0]    stored_sum;
    logic                 outside;
    logic [CNT_W-1:0]     inc_cnt;
    logic [CNT_W-1:0]     lim;
    logic                 hit_fault;
    logic [CNT_W-1:0]     new_cnt;
    logic                 wr_en;

    // Division pipeline registers.
    logic                 r_s2_valid;
    logic                 r_s2_fault;
    logic                 r_s2_avalid;
    logic                 r_s2_temp;
    logic [TSUM_W-1:0]    r_s2_sum;
    logic                 s2_neg;

    logic                 r_s3_valid;
    logic                 r_s3_fault;
    logic                 r_s3_avalid;
    logic                 r_s3_neg;
    logic [TSUM_W-1:0]    r_s3_mag;
    logic [2*TSUM_W-1:0]  s3_prod;

    logic                 r_s4_valid;
    logic                 r_s4_fault;
    logic                 r_s4_avalid;
    logic                 r_s4_neg;
    logic [SMP_W-1:0]     r_s4_quot;
    t_result              s4_result;

    // Result queue and credit.
    t_result              r_fifo [FIFO_DEPTH];
    logic [FPW-1:0]       r_wptr;
    logic [FPW-1:0]       r_rptr;
    logic [FCW-1:0]       r_fifo_cnt;
    logic [FCW-1:0]       r_credit;
    t_result              head;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_credit < FCW'(FIFO_DEPTH));
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_pop     = o_out_valid && i_out_ready;
    assign tenth       = (r_round == ROUND_LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt_under <= VOLT_UNDER_RST;
            r_volt_over  <= VOLT_OVER_RST;
            r_temp_under <= TEMP_UNDER_RST;
            r_temp_over  <= TEMP_OVER_RST;
            r_persist    <= PERSIST_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_VOLT_UNDER: r_volt_under <= i_cfg_data;
                CFG_VOLT_OVER:  r_volt_over  <= i_cfg_data;
                CFG_TEMP_UNDER: r_temp_under <= i_cfg_data[7:0];
                CFG_TEMP_OVER:  r_temp_over  <= i_cfg_data[7:0];
                CFG_PERSIST:    r_persist    <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round <= '0;
        end else if (in_accept && i_round_last) begin
            r_round <= tenth ? 4'd0 : r_round + 4'd1;
        end
    end

    always_comb begin
        mod_ok    = (5'(i_module_req) < 5'(MODULES));
        in_range  = i_is_temperature ? (mod_ok && (5'(i_position) < 5'(SENSORS_PER_MODULE)))
                                     : (mod_ok && (5'(i_position) < 5'(CELLS_PER_MODULE)));
        volt_addr = VAW'(i_module_req) * VAW'(CELLS_PER_MODULE) + VAW'(i_position);
        temp_addr = TAW'(i_module_req) * TAW'(SENSORS_PER_MODULE) + TAW'(i_position);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
        end
        r_s1_temp     <= i_is_temperature;
        r_s1_in_range <= in_range;
        r_s1_tenth    <= tenth;
        r_s1_addr     <= i_is_temperature ? CAW'(temp_addr) : CAW'(volt_addr);
        r_s1_sample   <= i_sample_value;
    end

    clpm_ram #(
        .WIDTH(VW),
        .DEPTH(V_CH)
    ) u_volt_ram (
        .i_clk  (i_clk),
        .i_we   (volt_we),
        .i_waddr(r_s1_addr[VAW-1:0]),
        .i_wdata(volt_wdata),
        .i_raddr(volt_addr),
        .o_rdata(volt_rdata)
    );

    clpm_ram #(
        .WIDTH(TW),
        .DEPTH(T_CH)
    ) u_temp_ram (
        .i_clk  (i_clk),
        .i_we   (temp_we),
        .i_waddr(r_s1_addr[TAW-1:0]),
        .i_wdata(temp_wdata),
        .i_raddr(temp_addr),
        .o_rdata(temp_rdata)
    );

    always_comb begin
        fwd_hit   = r_fwd_valid && (r_fwd_temp == r_s1_temp) && (r_fwd_addr == r_s1_addr);
        entry_vld = r_s1_temp ? r_tvld[r_s1_addr[TAW-1:0]] : r_vvld[r_s1_addr[VAW-1:0]];
        if (fwd_hit) begin
            old_cnt = r_fwd_cnt;
            old_sum = r_fwd_sum;
        end else if (!entry_vld) begin
            old_cnt = '0;
            old_sum = '0;
        end else if (r_s1_temp) begin
            old_cnt = temp_rdata[TW-1:TSUM_W];
            old_sum = temp_rdata[TSUM_W-1:0];
        end else begin
            old_cnt = volt_rdata[VW-1:VSUM_W];
            old_sum = TSUM_W'(volt_rdata[VSUM_W-1:0]);
        end

        if (r_s1_temp) begin
            outside = (r_s1_sample > SMP_W'(r_temp_over)) ||
                      (r_s1_sample < SMP_W'(r_temp_under));
            if (!r_s1_sample[SMP_W-1] && r_s1_sample[SMP_W-2]) begin
                add_val = TSUM_W'(16'sh7FFF);
            end else if (r_s1_sample[SMP_W-1] && !r_s1_sample[SMP_W-2]) begin
                add_val = {{(TSUM_W-16){1'b1}}, 16'h8000};
            end else begin
                add_val = TSUM_W'(r_s1_sample);
            end
        end else begin
            outside = (r_s1_sample > $signed({1'b0, r_volt_over})) ||
                      (r_s1_sample < $signed({1'b0, r_volt_under}));
            add_val = r_s1_sample[SMP_W-1] ? '0 : TSUM_W'(r_s1_sample[SMP_W-2:0]);
        end

        sum_full = old_sum + add_val;
        new_sum  = r_s1_temp ? sum_full : TSUM_W'(sum_full[VSUM_W-1:0]);
        stored_sum = r_s1_tenth ? '0 : new_sum;

        if (!outside) begin
            inc_cnt = '0;
        end else if (old_cnt != CNT_MAX) begin
            inc_cnt = old_cnt + CNT_W'(1);
        end else begin
            inc_cnt = old_cnt;
        end
        lim       = (r_persist == '0) ? CNT_W'(1) : r_persist;
        hit_fault = (inc_cnt >= lim);
        new_cnt   = hit_fault ? '0 : inc_cnt;

        wr_en      = r_s1_valid && r_s1_in_range;
        volt_we    = wr_en && !r_s1_temp;
        temp_we    = wr_en && r_s1_temp;
        volt_wdata = {new_cnt, stored_sum[VSUM_W-1:0]};
        temp_wdata = {new_cnt, stored_sum};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vvld      <= '0;
            r_tvld      <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (volt_we) begin
                r_vvld[r_s1_addr[VAW-1:0]] <= 1'b1;
            end
            if (temp_we) begin
                r_tvld[r_s1_addr[TAW-1:0]] <= 1'b1;
            end
            r_fwd_valid <= wr_en;
        end
        r_fwd_temp <= r_s1_temp;
        r_fwd_addr <= r_s1_addr;
        r_fwd_cnt  <= new_cnt;
        r_fwd_sum  <= stored_sum;
    end

    always_comb begin
        s2_neg  = r_s2_temp && r_s2_sum[TSUM_W-1];
        s3_prod = (2*TSUM_W)'(r_s3_mag) * (2*TSUM_W)'(DIV_MUL);
        s4_result.fault  = r_s4_fault;
        s4_result.avalid = r_s4_avalid;
        if (!r_s4_avalid) begin
            s4_result.value = '0;
        end else if (r_s4_neg) begin
            s4_result.value = -r_s4_quot;
        end else begin
            s4_result.value = r_s4_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
        r_s2_fault  <= r_s1_in_range && hit_fault;
        r_s2_avalid <= r_s1_in_range && r_s1_tenth;
        r_s2_temp   <= r_s1_temp;
        r_s2_sum    <= new_sum;

        r_s3_fault  <= r_s2_fault;
        r_s3_avalid <= r_s2_avalid;
        r_s3_neg    <= s2_neg;
        r_s3_mag    <= s2_neg ? -r_s2_sum : r_s2_sum;

        r_s4_fault  <= r_s3_fault;
        r_s4_avalid <= r_s3_avalid;
        r_s4_neg    <= r_s3_neg;
        r_s4_quot   <= s3_prod[DIV_SHIFT+SMP_W-1:DIV_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (r_s4_valid) begin
            r_fifo[r_wptr] <= s4_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_fifo_cnt <= '0;
            r_credit   <= '0;
        end else begin
            if (r_s4_valid) begin
                r_wptr <= r_wptr + FPW'(1);
            end
            if (out_pop) begin
                r_rptr <= r_rptr + FPW'(1);
            end
            r_fifo_cnt <= r_fifo_cnt + FCW'(r_s4_valid) - FCW'(out_pop);
            r_credit   <= r_credit + FCW'(in_accept) - FCW'(out_pop);
        end
    end

    assign head            = r_fifo[r_rptr];
    assign o_out_valid     = (r_fifo_cnt != '0);
    assign o_fault         = head.fault;
    assign o_average_valid = head.avalid;
    assign o_average_value = head.value;

`ifndef NO_ASSERTIONS
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= FCW'(FIFO_DEPTH))
        else $error("Credit count exceeds the result queue depth.");

    a_queue_within_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_cnt <= r_credit)
        else $error("Result queue holds more entries than outstanding transactions.");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid |-> (r_fifo_cnt < FCW'(FIFO_DEPTH)) || out_pop)
        else $error("Result pushed into a full queue.");

    a_fwd_follows_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_fwd_valid && (r_fwd_addr == $past(r_s1_addr)))
        else $error("Forwarding register missed a write-back.");
`endif

endmodule

/* dv/cell_limit_persistence_monitor_tb.sv */
// Self-checking testbench for the cell limit persistence monitor.
module cell_limit_persistence_monitor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clpm_pkg::*;

    localparam int VOLT_CH = DEF_MODULES * DEF_CELLS;
    localparam int TEMP_CH = DEF_MODULES * DEF_SENSORS;

    typedef struct {
        logic [2:0]              module_idx;
        logic [2:0]              pos;
        logic                    is_temp;
        logic signed [SMP_W-1:0] value;
        logic                    last;
    } t_reading;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [2:0]              i_module_req = '0;
    logic [2:0]              i_position = '0;
    logic                    i_is_temperature = 1'b0;
    logic signed [SMP_W-1:0] i_sample_value = '0;
    logic                    i_round_last = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b1;
    logic                    o_fault;
    logic                    o_average_valid;
    logic signed [SMP_W-1:0] o_average_value;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    cell_limit_persistence_monitor u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_module_req     (i_module_req),
        .i_position       (i_position),
        .i_is_temperature (i_is_temperature),
        .i_sample_value   (i_sample_value),
        .i_round_last     (i_round_last),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_fault          (o_fault),
        .o_average_valid  (o_average_valid),
        .o_average_value  (o_average_value),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Shadow copy of the limits and the per-channel state.
    logic [15:0]        lim_volt_under;
    logic [15:0]        lim_volt_over;
    logic signed [7:0]  lim_temp_under;
    logic signed [7:0]  lim_temp_over;
    logic [CNT_W-1:0]   persist;
    logic [CNT_W-1:0]   volt_runs [VOLT_CH];
    logic [CNT_W-1:0]   temp_runs [TEMP_CH];
    logic [VSUM_W-1:0]  volt_acc [VOLT_CH];
    int                 temp_acc [TEMP_CH];
    logic [3:0]         round_no;

    t_result  expected_reports [$];
    t_result  oldest_report;
    t_reading hot_set [4];
    bit       hot_drift [4];
    bit       calm_tail = 1'b0;
    int       mismatch_count = 0;
    int       readings_sent = 0;
    int       faults_seen = 0;
    int       averages_seen = 0;
    int       settings_used = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_shadow();
        lim_volt_under = VOLT_UNDER_RST;
        lim_volt_over  = VOLT_OVER_RST;
        lim_temp_under = TEMP_UNDER_RST;
        lim_temp_over  = TEMP_OVER_RST;
        persist        = PERSIST_RST;
        foreach (volt_runs[i]) begin
            volt_runs[i] = '0;
            volt_acc[i]  = '0;
        end
        foreach (temp_runs[i]) begin
            temp_runs[i] = '0;
            temp_acc[i]  = 0;
        end
        round_no = '0;
    endfunction

    function automatic bit bump_run(inout logic [CNT_W-1:0] run, input bit outside);
        int c;
        int lim;
        lim = (persist == 0) ? 1 : int'(persist);
        c = run;
        if (outside) begin
            if (c < CNT_MAX) c++;
        end else begin
            c = 0;
        end
        if (c >= lim) begin
            run = '0;
            return 1'b1;
        end
        run = c[CNT_W-1:0];
        return 1'b0;
    endfunction

    function automatic t_result judge_reading(input t_reading r);
        t_result res;
        int      v;
        int      ch;
        int      add;
        bit      outside;
        bit      tenth;
        res   = '0;
        v     = r.value;
        tenth = (round_no == ROUND_LAST_IDX);
        if (!r.is_temp) begin
            if (r.module_idx < DEF_MODULES && r.pos < DEF_CELLS) begin
                ch      = r.module_idx * DEF_CELLS + r.pos;
                add     = (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
                outside = (v > int'(lim_volt_over)) || (v < int'(lim_volt_under));
                volt_acc[ch] = VSUM_W'(volt_acc[ch] + add);
                res.fault = bump_run(volt_runs[ch], outside);
                if (tenth) begin
                    res.avalid   = 1'b1;
                    res.value    = SMP_W'(volt_acc[ch] / 10);
                    volt_acc[ch] = '0;
                end
            end
        end else begin
            if (r.module_idx < DEF_MODULES && r.pos < DEF_SENSORS) begin
                ch      = r.module_idx * DEF_SENSORS + r.pos;
                add     = (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
                outside = (v > int'(lim_temp_over)) || (v < int'(lim_temp_under));
                temp_acc[ch] += add;
                res.fault = bump_run(temp_runs[ch], outside);
                if (tenth) begin
                    res.avalid   = 1'b1;
                    res.value    = SMP_W'(temp_acc[ch] / 10);
                    temp_acc[ch] = 0;
                end
            end
        end
        if (r.last) round_no = tenth ? 4'd0 : round_no + 4'd1;
        return res;
    endfunction

    function automatic t_reading reading(input int m, input int p, input bit t,
                                         input int v, input bit l);
        t_reading r;
        r.module_idx = m[2:0];
        r.pos        = p[2:0];
        r.is_temp    = t;
        r.value      = v[SMP_W-1:0];
        r.last       = l;
        return r;
    endfunction

    function automatic logic signed [SMP_W-1:0] pick_value(input bit is_t, input bit drift);
        int lo;
        int hi;
        int v;
        int sel;
        if (is_t) begin
            lo = lim_temp_under;
            hi = lim_temp_over;
        end else begin
            lo = lim_volt_under;
            hi = lim_volt_over;
        end
        if (drift) sel = ($urandom_range(0, 9) == 0) ? 0 : 2 + int'($urandom_range(0, 1));
        else sel = $urandom_range(0, 5);
        case (sel)
            0, 1: v = (lo <= hi) ? lo + int'($urandom_range(0, hi - lo))
                                 : hi + int'($urandom_range(0, lo - hi));
            2: v = hi + int'($urandom_range(1, 3));
            3: v = lo - int'($urandom_range(1, 3));
            4: v = int'($urandom_range(0, 98303)) - 32768;
            default: begin
                case ($urandom_range(0, 3))
                    0: v = -32768;
                    1: v = -1;
                    2: v = 0;
                    default: v = 65535;
                endcase
            end
        endcase
        if (v < -32768) v = -32768;
        if (v > 65535) v = 65535;
        return SMP_W'(v);
    endfunction

    function automatic void reroll_hot(input int k);
        hot_set[k].is_temp    = 1'($urandom_range(0, 1));
        hot_set[k].module_idx = 3'($urandom_range(0, 7));
        hot_set[k].pos        = hot_set[k].is_temp ? 3'($urandom_range(0, 3))
                                                   : 3'($urandom_range(0, 5));
        hot_drift[k]          = ($urandom_range(0, 2) != 0);
    endfunction

    // Most traffic lands on a few channels that stay out of window for a while,
    // so that the persistence counters actually run up.
    function automatic t_reading draw_reading();
        t_reading r;
        int       k;
        if ($urandom_range(0, 9) < 6) begin
            k = $urandom_range(0, 3);
            if ($urandom_range(0, 39) == 0) reroll_hot(k);
            r       = hot_set[k];
            r.value = pick_value(r.is_temp, hot_drift[k]);
        end else begin
            r.module_idx = 3'($urandom_range(0, 7));
            r.pos        = 3'($urandom_range(0, 5));
            r.is_temp    = 1'($urandom_range(0, 1));
            r.value      = pick_value(r.is_temp, 1'b0);
        end
        r.last = ($urandom_range(0, 5) == 0);
        return r;
    endfunction

    task automatic send_reading(input t_reading r);
        if (!calm_tail && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_module_req     <= r.module_idx;
        i_position       <= r.pos;
        i_is_temperature <= r.is_temp;
        i_sample_value   <= r.value;
        i_round_last     <= r.last;
        do @(posedge i_clk); while (!o_in_ready);
        expected_reports.push_back(judge_reading(r));
        readings_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_VOLT_UNDER: lim_volt_under = data;
            CFG_VOLT_OVER:  lim_volt_over  = data;
            CFG_TEMP_UNDER: lim_temp_under = data[7:0];
            CFG_TEMP_OVER:  lim_temp_over  = data[7:0];
            CFG_PERSIST:    persist        = data[CNT_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [15:0] volt_under, input logic [15:0] volt_over,
                              input logic signed [7:0] temp_under,
                              input logic signed [7:0] temp_over,
                              input logic [CNT_W-1:0] count);
        settle();
        write_register(CFG_VOLT_UNDER, volt_under);
        write_register(CFG_VOLT_OVER, volt_over);
        write_register(CFG_TEMP_UNDER, {{8{temp_under[7]}}, temp_under});
        write_register(CFG_TEMP_OVER, {{8{temp_over[7]}}, temp_over});
        write_register(CFG_PERSIST, {{(16 - CNT_W){1'b0}}, count});
        settings_used++;
    endtask

    task automatic run_random(input int count, input bit hold_midway);
        for (int k = 0; k < 4; k++) reroll_hot(k);
        for (int n = 0; n < count; n++) begin
            if (hold_midway && n == count / 2) settle();
            send_reading(draw_reading());
        end
    endtask

    task automatic test_default_limits();
        send_reading(reading(0, 0, 1'b0, 31000, 1'b0));
        send_reading(reading(0, 1, 1'b0, 30999, 1'b0));
        send_reading(reading(0, 2, 1'b0, 41000, 1'b0));
        send_reading(reading(0, 3, 1'b0, 41001, 1'b0));
        send_reading(reading(7, 5, 1'b0, -32768, 1'b0));
        send_reading(reading(7, 4, 1'b0, 65535, 1'b0));
        send_reading(reading(1, 0, 1'b1, 10, 1'b0));
        send_reading(reading(1, 1, 1'b1, 9, 1'b0));
        send_reading(reading(1, 2, 1'b1, 55, 1'b0));
        send_reading(reading(1, 3, 1'b1, 56, 1'b0));
        send_reading(reading(2, 3, 1'b1, 65535, 1'b0));
        send_reading(reading(6, 5, 1'b1, -40, 1'b1));
    endtask

    task automatic test_zero_persistence();
        set_limits(VOLT_UNDER_RST, VOLT_OVER_RST, TEMP_UNDER_RST, TEMP_OVER_RST, '0);
        send_reading(reading(4, 0, 1'b0, 50000, 1'b0));
        send_reading(reading(4, 1, 1'b1, -20, 1'b0));
    endtask

    task automatic test_ten_round_average();
        int step;
        step = 0;
        while (round_no != ROUND_LAST_IDX) begin
            send_reading(reading(5, 2, 1'b1, -7 - 3 * step, 1'b1));
            step++;
        end
        send_reading(reading(5, 0, 1'b0, 40000, 1'b0));
        send_reading(reading(5, 2, 1'b1, -5, 1'b1));
        send_reading(reading(5, 2, 1'b1, -5, 1'b0));
    endtask

    task automatic test_random_windows();
        set_limits(16'($urandom_range(28000, 34000)), 16'($urandom_range(38000, 44000)),
                   8'(-int'($urandom_range(0, 40))), 8'($urandom_range(40, 90)),
                   CNT_W'($urandom_range(1, 6)));
        run_random(200, 1'b1);
        set_limits(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   CNT_W'($urandom_range(1, 6)));
        run_random(200, 1'b0);
        set_limits(16'($urandom_range(30000, 32000)), 16'($urandom_range(40000, 42000)),
                   8'($urandom_range(0, 20)), 8'($urandom_range(40, 60)),
                   CNT_W'($urandom_range(2, 10)));
        run_random(200, 1'b0);
    endtask

    task automatic test_open_window();
        set_limits(16'd0, 16'd65535, -8'sd128, 8'sd127, CNT_MAX);
        run_random(200, 1'b0);
    endtask

    task automatic test_closed_window();
        set_limits(16'd65535, 16'd0, 8'sd127, -8'sd128, 10'd1);
        run_random(200, 1'b0);
    endtask

    task automatic test_persistence_carry();
        set_limits(VOLT_UNDER_RST, VOLT_OVER_RST, TEMP_UNDER_RST, TEMP_OVER_RST, 10'd500);
        run_random(150, 1'b0);
        settle();
        write_register(CFG_PERSIST, 16'd2);
        settings_used++;
        run_random(150, 1'b0);
    endtask

    task automatic test_steady_stream();
        set_limits(VOLT_UNDER_RST, VOLT_OVER_RST, TEMP_UNDER_RST, TEMP_OVER_RST, 10'd3);
        calm_tail = 1'b1;
        run_random(400, 1'b0);
    endtask

    initial begin
        forever begin
            repeat ($urandom_range(1, 60)) @(posedge i_clk);
            if (!calm_tail) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_reports.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected, expected none, got f=%0b av=%0b avg=%0d",
                         $time, o_fault, o_average_valid, o_average_value);
            end else begin
                oldest_report = expected_reports.pop_front();
                faults_seen   += oldest_report.fault;
                averages_seen += oldest_report.avalid;
                if (o_fault !== oldest_report.fault || o_average_valid !== oldest_report.avalid ||
                    o_average_value !== oldest_report.value) begin
                    mismatch_count++;
                    $display("%0t: expected f=%0b av=%0b avg=%0d, got f=%0b av=%0b avg=%0d",
                             $time, oldest_report.fault, oldest_report.avalid,
                             $signed(oldest_report.value), o_fault, o_average_valid,
                             o_average_value);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        clear_shadow();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_limits();
        test_zero_persistence();
        test_ten_round_average();
        test_random_windows();
        test_open_window();
        test_closed_window();
        test_persistence_carry();
        test_steady_stream();
        settle();
        repeat (20) @(posedge i_clk);
        $display("Checked %0d measurements under %0d limit settings.", readings_sent, settings_used);
        $display("The results held %0d fault reports and %0d ten-round averages.",
                 faults_seen, averages_seen);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* cell_limit_persistence_monitor.f */
src/clpm_pkg.sv
src/clpm_ram.sv
src/cell_limit_persistence_monitor.sv
dv/cell_limit_persistence_monitor_tb.sv
